[rtl/hid_kbd_pkg.sv]
`default_nettype none

package hid_kbd_pkg;

    localparam int KEY_SLOTS_DEF = 6;
    localparam int MAX_SLOTS     = 6;
    localparam int KEY_MAP_DEPTH = 256;
    localparam int ADDR_W        = $clog2(KEY_MAP_DEPTH);

    localparam logic [7:0] SHIFT_MASK  = 8'h22;
    localparam logic [7:0] CTRL_MASK   = 8'h11;
    localparam logic [7:0] CODE_CAPS   = 8'h39;
    localparam logic [7:0] CODE_NUM    = 8'h53;
    localparam logic [7:0] CODE_SCROLL = 8'h47;
    localparam logic [7:0] CODE_C      = 8'h06;
    localparam logic [7:0] CODE_PAUSE  = 8'h48;

    localparam logic [2:0] NUM_LED    = 3'b001;
    localparam logic [2:0] CAPS_LED   = 3'b010;
    localparam logic [2:0] SCROLL_LED = 3'b100;

    typedef struct packed {
        logic [7:0] modifier_byte;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } t_report;

    typedef struct packed {
        logic        event_valid;
        logic [7:0]  scan_code;
        logic        key_went_down;
        logic        key_went_up;
        logic [7:0]  modifier_state;
        logic        caps_active;
        logic        break_request;
        logic [2:0]  lock_leds;
        logic        lock_leds_changed;
        logic [31:0] report_count;
        logic        last;
    } t_key_event;

endpackage

`default_nettype wire

[rtl/hid_keyboard_report_to_key_events.sv]
`default_nettype none

// Boot keyboard report decoder. Each accepted report (modifier byte plus key
// slots, zero meaning empty) is compared against a 256 x 1 key map held in a
// synchronous RAM; one beat is sent per changed key in ascending usage-code
// order, followed by a closing beat (last = 1) carrying the lock LED bits,
// an LED-changed flag and the 32-bit report count. The map is swept one
// entry per cycle, but holds on a changed key while the output stalls,
// with read and write-back overlapped, and one report is decoded at a
// time. After reset the map is cleared in a pass during which o_in_stall
// stays high.
module hid_keyboard_report_to_key_events #(
    parameter int KEY_SLOTS = hid_kbd_pkg::KEY_SLOTS_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire hid_kbd_pkg::t_report i_in_data,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output hid_kbd_pkg::t_key_event   o_out_data
);

    localparam int AW = hid_kbd_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST_ADDR = {AW{1'b1}};

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CLOSE
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_addr;
    logic [7:0] r_mods;
    logic [7:0] r_slot [hid_kbd_pkg::MAX_SLOTS];
    logic r_caps;
    logic r_ctrl;
    logic [2:0] r_toggle;
    logic [2:0] r_leds;
    logic [31:0] r_count;
    logic r_out_valid;
    hid_kbd_pkg::t_key_event r_out;

    logic r_key_map [hid_kbd_pkg::KEY_MAP_DEPTH];
    logic r_rd;

    logic mem_we;
    logic mem_wdata;
    logic mem_re;
    logic [AW-1:0] mem_raddr;

    logic w_accept;
    logic w_out_free;
    logic w_cur;
    logic w_diff;
    logic w_down;
    logic w_adv;
    logic w_load;
    logic [7:0] w_in_slot [hid_kbd_pkg::MAX_SLOTS];
    logic [2:0] n_leds;
    logic [31:0] n_count;
    logic [2:0] n_toggle;

    assign w_in_slot[0] = i_in_data.key_slot_0;
    assign w_in_slot[1] = i_in_data.key_slot_1;
    assign w_in_slot[2] = i_in_data.key_slot_2;
    assign w_in_slot[3] = i_in_data.key_slot_3;
    assign w_in_slot[4] = i_in_data.key_slot_4;
    assign w_in_slot[5] = i_in_data.key_slot_5;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // membership of the scanned code in this report; code 0 never counts
    always_comb begin
        w_cur = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_slot[i] != 8'd0 && r_slot[i] == 8'(r_addr)) begin
                w_cur = 1'b1;
            end
        end
    end

    assign w_diff = w_cur ^ r_rd;
    assign w_down = w_cur && !r_rd;
    assign w_adv  = (r_state == S_SCAN) && (!w_diff || w_out_free);
    assign w_load = ((r_state == S_SCAN) && w_adv && w_diff) ||
                    ((r_state == S_CLOSE) && w_out_free);

    always_comb begin
        n_toggle = r_toggle;
        if (w_down) begin
            if (8'(r_addr) == hid_kbd_pkg::CODE_CAPS) n_toggle = n_toggle | hid_kbd_pkg::CAPS_LED;
            if (8'(r_addr) == hid_kbd_pkg::CODE_NUM) n_toggle = n_toggle | hid_kbd_pkg::NUM_LED;
            if (8'(r_addr) == hid_kbd_pkg::CODE_SCROLL) begin
                n_toggle = n_toggle | hid_kbd_pkg::SCROLL_LED;
            end
        end
    end

    assign n_leds  = r_leds ^ r_toggle;
    assign n_count = r_count + 32'd1;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                mem_re = w_accept;
            end
            S_SCAN: begin
                mem_we    = w_adv;
                mem_wdata = w_cur;
                mem_re    = w_adv && (r_addr != LAST_ADDR);
                mem_raddr = AW'(r_addr + 1'b1);
            end
            S_CLOSE: begin
            end
            default: begin
            end
        endcase
    end

    // write goes to the entry just checked, read to the next one: never the same entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_key_map[r_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_key_map[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_leds      <= '0;
            r_count     <= '0;
            r_toggle    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= AW'(r_addr + 1'b1);
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_mods   <= i_in_data.modifier_byte;
                        r_slot   <= w_in_slot;
                        r_ctrl   <= |(i_in_data.modifier_byte & hid_kbd_pkg::CTRL_MASK);
                        r_caps   <= |(i_in_data.modifier_byte & hid_kbd_pkg::SHIFT_MASK)
                                    || |(r_leds & hid_kbd_pkg::CAPS_LED);
                        r_toggle <= '0;
                        r_addr   <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_adv) begin
                        r_toggle <= n_toggle;
                        if (w_diff) begin
                            r_out.event_valid       <= 1'b1;
                            r_out.scan_code         <= 8'(r_addr);
                            r_out.key_went_down     <= w_down;
                            r_out.key_went_up       <= !w_down;
                            r_out.modifier_state    <= r_mods;
                            r_out.caps_active       <= r_caps;
                            r_out.break_request     <= w_down &&
                                ((8'(r_addr) == hid_kbd_pkg::CODE_C && r_ctrl) ||
                                 8'(r_addr) == hid_kbd_pkg::CODE_PAUSE);
                            r_out.lock_leds         <= r_leds;
                            r_out.lock_leds_changed <= 1'b0;
                            r_out.report_count      <= '0;
                            r_out.last              <= 1'b0;
                        end
                        if (r_addr == LAST_ADDR) begin
                            r_state <= S_CLOSE;
                        end else begin
                            r_addr <= AW'(r_addr + 1'b1);
                        end
                    end
                end
                S_CLOSE: begin
                    if (w_out_free) begin
                        r_leds                  <= n_leds;
                        r_count                 <= n_count;
                        r_out.event_valid       <= 1'b0;
                        r_out.scan_code         <= 8'd0;
                        r_out.key_went_down     <= 1'b0;
                        r_out.key_went_up       <= 1'b0;
                        r_out.modifier_state    <= r_mods;
                        r_out.caps_active       <= r_caps;
                        r_out.break_request     <= 1'b0;
                        r_out.lock_leds         <= n_leds;
                        r_out.lock_leds_changed <= |r_toggle;
                        r_out.report_count      <= n_count;
                        r_out.last              <= 1'b1;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after accept");

    a_event_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_valid) |->
            $onehot({o_out_data.key_went_down, o_out_data.key_went_up}))
        else $error("event beat without exactly one direction");

    a_no_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.event_valid) |-> (o_out_data.scan_code != 8'd0))
        else $error("event for empty code");

    a_quiet_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("output beat during map clear");

endmodule

`default_nettype wire

[bench/hid_key_event_checker.sv]
`timescale 1ns / 1ps

module hid_key_event_checker (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire                      i_in_stall,
    input  hid_kbd_pkg::t_report     i_in_data,
    input  wire                      i_out_valid,
    input  wire                      i_out_stall,
    input  hid_kbd_pkg::t_key_event  i_out_data,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_event_count,
    output int                       o_break_count,
    output int                       o_led_updates
);

    logic [hid_kbd_pkg::KEY_MAP_DEPTH-1:0] held_map     = '0;
    logic [2:0]                            led_bits     = '0;
    logic [31:0]                           reports_seen = '0;

    hid_kbd_pkg::t_key_event expected_events[$];
    hid_kbd_pkg::t_key_event want;
    int         fails       = 0;
    int         events      = 0;
    int         breaks      = 0;
    int         led_updates = 0;

    // Expected beats for one report: one per changed key, then the closing beat.
    task automatic decode_report(input hid_kbd_pkg::t_report rpt);
        logic [7:0]                            slots [hid_kbd_pkg::MAX_SLOTS];
        logic [hid_kbd_pkg::KEY_MAP_DEPTH-1:0] now_map;
        logic                                  shift_held;
        logic                                  ctrl_held;
        logic                                  caps;
        logic [2:0]                            leds_before;
        logic [2:0]                            toggle;
        hid_kbd_pkg::t_key_event               ev;
        slots = '{rpt.key_slot_0, rpt.key_slot_1, rpt.key_slot_2,
                  rpt.key_slot_3, rpt.key_slot_4, rpt.key_slot_5};
        now_map = '0;
        for (int s = 0; s < hid_kbd_pkg::KEY_SLOTS_DEF; s++) begin
            if (slots[s] != 8'd0)
                now_map[slots[s]] = 1'b1;
        end
        shift_held  = |(rpt.modifier_byte & hid_kbd_pkg::SHIFT_MASK);
        ctrl_held   = |(rpt.modifier_byte & hid_kbd_pkg::CTRL_MASK);
        leds_before = led_bits;
        caps        = shift_held | (|(leds_before & hid_kbd_pkg::CAPS_LED));
        toggle      = '0;

        for (int code = 0; code < hid_kbd_pkg::KEY_MAP_DEPTH; code++) begin
            if (held_map[code] != now_map[code]) begin
                ev                = '0;
                ev.event_valid    = 1'b1;
                ev.scan_code      = 8'(code);
                ev.key_went_down  = now_map[code];
                ev.key_went_up    = held_map[code];
                ev.modifier_state = rpt.modifier_byte;
                ev.caps_active    = caps;
                ev.lock_leds      = leds_before;
                if (now_map[code]) begin
                    ev.break_request = (code == hid_kbd_pkg::CODE_PAUSE) ||
                                       (code == hid_kbd_pkg::CODE_C && ctrl_held);
                    if (code == hid_kbd_pkg::CODE_CAPS)   toggle |= hid_kbd_pkg::CAPS_LED;
                    if (code == hid_kbd_pkg::CODE_NUM)    toggle |= hid_kbd_pkg::NUM_LED;
                    if (code == hid_kbd_pkg::CODE_SCROLL) toggle |= hid_kbd_pkg::SCROLL_LED;
                end
                expected_events.push_back(ev);
            end
        end

        held_map     = now_map;
        led_bits     = led_bits ^ toggle;
        reports_seen = reports_seen + 32'd1;

        ev                   = '0;
        ev.modifier_state    = rpt.modifier_byte;
        ev.caps_active       = caps;
        ev.lock_leds         = led_bits;
        ev.lock_leds_changed = |toggle;
        ev.report_count      = reports_seen;
        ev.last              = 1'b1;
        expected_events.push_back(ev);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // output side first: a beat can never belong to a report taken this edge
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected output beat: scan_code %0h, last %0b",
                           i_out_data.scan_code, i_out_data.last);
                    fails++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_valid",       32'(want.event_valid),
                                32'(i_out_data.event_valid));
                    check_field("scan_code",         32'(want.scan_code),
                                32'(i_out_data.scan_code));
                    check_field("key_went_down",     32'(want.key_went_down),
                                32'(i_out_data.key_went_down));
                    check_field("key_went_up",       32'(want.key_went_up),
                                32'(i_out_data.key_went_up));
                    check_field("modifier_state",    32'(want.modifier_state),
                                32'(i_out_data.modifier_state));
                    check_field("caps_active",       32'(want.caps_active),
                                32'(i_out_data.caps_active));
                    check_field("break_request",     32'(want.break_request),
                                32'(i_out_data.break_request));
                    check_field("lock_leds",         32'(want.lock_leds),
                                32'(i_out_data.lock_leds));
                    check_field("lock_leds_changed", 32'(want.lock_leds_changed),
                                32'(i_out_data.lock_leds_changed));
                    check_field("report_count",      want.report_count,
                                i_out_data.report_count);
                    check_field("last",              32'(want.last),
                                32'(i_out_data.last));
                    if (want.event_valid)       events++;
                    if (want.break_request)     breaks++;
                    if (want.lock_leds_changed) led_updates++;
                end
            end
            if (i_in_valid && !i_in_stall)
                decode_report(i_in_data);
        end
        o_fail_count  <= fails;
        o_pending     <= expected_events.size();
        o_event_count <= events;
        o_break_count <= breaks;
        o_led_updates <= led_updates;
    end

endmodule

[bench/hid_keyboard_report_to_key_events_test.sv]
`timescale 1ns / 1ps

module hid_keyboard_report_to_key_events_test;

    localparam int REPORT_COUNT = 350;
    localparam int QUIET_TAIL   = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    i_out_stall = 1'b0;
    hid_kbd_pkg::t_report    i_in_data   = '0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    hid_kbd_pkg::t_key_event o_out_data;

    int fail_count;
    int pending;
    int event_count;
    int break_count;
    int led_updates;

    bit         quiet        = 1'b0;
    int         reports_sent = 0;
    int         stall_left   = 0;
    int         idle_cycles  = 0;
    logic [7:0] held_keys[$];

    hid_keyboard_report_to_key_events uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    hid_key_event_checker events_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_event_count (event_count),
        .o_break_count (break_count),
        .o_led_updates (led_updates)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // receiver: alternating stall and run bursts, with no stalls once quiet is set
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_stall <= !i_out_stall;
        end else begin
            stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat on either channel for %0d cycles", idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic hid_kbd_pkg::t_report make_report(input logic [7:0] mods,
                                            input logic [7:0] s0, input logic [7:0] s1,
                                            input logic [7:0] s2, input logic [7:0] s3,
                                            input logic [7:0] s4, input logic [7:0] s5);
        hid_kbd_pkg::t_report rpt;
        rpt.modifier_byte = mods;
        rpt.key_slot_0    = s0;
        rpt.key_slot_1    = s1;
        rpt.key_slot_2    = s2;
        rpt.key_slot_3    = s3;
        rpt.key_slot_4    = s4;
        rpt.key_slot_5    = s5;
        return rpt;
    endfunction

    // Realistic typing: at most one key pressed and one released per report, or all released at once.
    function automatic hid_kbd_pkg::t_report typing_report();
        logic [7:0] slots [6];
        logic [7:0] code;
        logic [7:0] mods;
        bit         seen;
        int         pos;
        if (held_keys.size() > 0 && $urandom_range(0, 2) == 0)
            held_keys.delete($urandom_range(0, held_keys.size() - 1));
        if ($urandom_range(0, 15) == 0)
            held_keys.delete();
        if (held_keys.size() < hid_kbd_pkg::KEY_SLOTS_DEF && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
                0:       code = hid_kbd_pkg::CODE_CAPS;
                1:       code = hid_kbd_pkg::CODE_NUM;
                2:       code = hid_kbd_pkg::CODE_SCROLL;
                3:       code = hid_kbd_pkg::CODE_C;
                4:       code = hid_kbd_pkg::CODE_PAUSE;
                5, 6, 7: code = 8'($urandom_range(8'h04, 8'h27));
                default: code = 8'($urandom_range(1, 255));
            endcase
            seen = 1'b0;
            foreach (held_keys[k])
                if (held_keys[k] == code) seen = 1'b1;
            if (!seen)
                held_keys.push_back(code);
        end

        foreach (slots[s])
            slots[s] = 8'd0;
        foreach (held_keys[k]) begin
            do pos = $urandom_range(0, 5); while (slots[pos] != 8'd0);
            slots[pos] = held_keys[k];
        end
        // sometimes repeat a held code in a spare slot
        if (held_keys.size() > 0 && held_keys.size() < 6 && $urandom_range(0, 4) == 0) begin
            do pos = $urandom_range(0, 5); while (slots[pos] != 8'd0);
            slots[pos] = held_keys[$urandom_range(0, held_keys.size() - 1)];
        end

        case ($urandom_range(0, 3))
            0:       mods = 8'h00;
            1:       mods = 8'h01 << $urandom_range(0, 7);
            default: mods = 8'($urandom_range(0, 255));
        endcase
        return make_report(mods, slots[0], slots[1], slots[2], slots[3], slots[4], slots[5]);
    endfunction

    // Arbitrary slot contents; the typing model picks up from whatever is held after it.
    function automatic hid_kbd_pkg::t_report noise_report();
        logic [7:0] slots [6];
        bit         seen;
        held_keys.delete();
        foreach (slots[s]) begin
            slots[s] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
            if (slots[s] != 8'd0) begin
                seen = 1'b0;
                foreach (held_keys[k])
                    if (held_keys[k] == slots[s]) seen = 1'b1;
                if (!seen)
                    held_keys.push_back(slots[s]);
            end
        end
        return make_report(8'($urandom_range(0, 255)), slots[0], slots[1], slots[2],
                           slots[3], slots[4], slots[5]);
    endfunction

    // Called at a clock edge; returns at the edge where the beat is taken.
    task automatic send_report(input hid_kbd_pkg::t_report rpt);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= rpt;
        do @(posedge i_clk); while (o_in_stall);
        reports_sent++;
    endtask

    task automatic drain_events();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        hid_kbd_pkg::t_report rpt;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h11, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h02, hid_kbd_pkg::CODE_CAPS, hid_kbd_pkg::CODE_CAPS,
                                hid_kbd_pkg::CODE_CAPS, hid_kbd_pkg::CODE_CAPS,
                                hid_kbd_pkg::CODE_CAPS, hid_kbd_pkg::CODE_CAPS));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h00, hid_kbd_pkg::CODE_NUM, hid_kbd_pkg::CODE_SCROLL,
                                8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h00, hid_kbd_pkg::CODE_CAPS, hid_kbd_pkg::CODE_NUM,
                                hid_kbd_pkg::CODE_SCROLL, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // all three lock keys go down together
        send_report(make_report(8'h00, hid_kbd_pkg::CODE_CAPS, hid_kbd_pkg::CODE_NUM,
                                hid_kbd_pkg::CODE_SCROLL, hid_kbd_pkg::CODE_CAPS,
                                hid_kbd_pkg::CODE_NUM, hid_kbd_pkg::CODE_SCROLL));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h10, hid_kbd_pkg::CODE_C, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00));
        send_report(make_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h20, hid_kbd_pkg::CODE_C, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00));
        send_report(make_report(8'h00, hid_kbd_pkg::CODE_PAUSE, 8'h00, 8'h00, 8'h00, 8'h00,
                                8'h00));
        send_report(make_report(8'hFF, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                hid_kbd_pkg::CODE_PAUSE));
        // six ups and six downs in one report
        send_report(make_report(8'h00, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15));
        send_report(make_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
        send_report(make_report(8'hAA, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00));
        send_report(make_report(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        drain_events();

        for (int n = 0; n < REPORT_COUNT; n++) begin
            quiet <= (n >= REPORT_COUNT - QUIET_TAIL);
            if (n == REPORT_COUNT / 2)
                drain_events();
            rpt = ($urandom_range(0, 4) == 0) ? noise_report() : typing_report();
            send_report(rpt);
        end

        drain_events();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Decoded %0d reports into %0d key events, %0d of them break requests",
                 reports_sent, event_count, break_count);
        $display("Lock LEDs changed in %0d reports, under random input gaps and output stalls",
                 led_updates);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
